@@ hw/rtl/assert_macros.svh @@
// Assertion helpers for the pedal conditioning block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define APC_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("pedal conditioning assertion failed");
`define APC_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("pedal conditioning assertion failed");
`else
`define APC_ASSERT(lbl, clk, rst, prop)
`define APC_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

@@ hw/rtl/apc_pkg.sv @@
package apc_pkg;

   localparam int AdcW      = 12;
   localparam int FracW     = 17;
   localparam int LevelW    = 25;
   localparam int ThrW      = 13;
   localparam int CsrW      = 16;
   localparam int CsrIdxW   = 3;
   localparam int MergeDendW = 33;
   localparam int MergeDsorW = 16;
   localparam int EmaW      = 32;
   localparam int TolProdW  = 20;

   localparam logic [FracW-1:0] FracOne = 17'd65536;
   localparam logic [AdcW-1:0]  RawLow  = 12'd100;
   localparam logic [AdcW-1:0]  RawHigh = 12'd4050;
   localparam int               SmoothN = 50;
   localparam logic [6:0]       DzMax   = 7'd99;

   // reciprocals: ceil(2^36/50) exact for numerators below 2^32,
   // ceil(2^26/100) exact for numerators below 2^20
   localparam logic [30:0] Recip50    = 31'd1374389535;
   localparam int          Recip50Sh  = 36;
   localparam logic [19:0] Recip100   = 20'd671089;
   localparam int          Recip100Sh = 26;

   localparam logic [AdcW-1:0] S1MinRst  = 12'd1800;
   localparam logic [AdcW-1:0] S1MaxRst  = 12'd3600;
   localparam logic [AdcW-1:0] S2MinRst  = 12'd600;
   localparam logic [AdcW-1:0] S2MaxRst  = 12'd2300;
   localparam logic [AdcW-1:0] OffRst    = 12'd1280;
   localparam logic [6:0]      TolRst    = 7'd10;
   localparam logic [6:0]      DzRst     = 7'd5;
   localparam logic [15:0]     FaultTRst = 16'd100;

   localparam logic [CsrIdxW-1:0] CSR_S1_MIN  = 3'd0;
   localparam logic [CsrIdxW-1:0] CSR_S1_MAX  = 3'd1;
   localparam logic [CsrIdxW-1:0] CSR_S2_MIN  = 3'd2;
   localparam logic [CsrIdxW-1:0] CSR_S2_MAX  = 3'd3;
   localparam logic [CsrIdxW-1:0] CSR_OFFSET  = 3'd4;
   localparam logic [CsrIdxW-1:0] CSR_TOL_PCT = 3'd5;
   localparam logic [CsrIdxW-1:0] CSR_DZ_PCT  = 3'd6;
   localparam logic [CsrIdxW-1:0] CSR_FAULT_T = 3'd7;

   typedef struct packed {
      logic [11:0] sensor1_raw;
      logic [11:0] sensor2_raw;
      logic [31:0] now_ms;
      logic        clear_fault;
   } req_type;

   typedef struct packed {
      logic [16:0] throttle;
      logic        plausible_now;
      logic        fault_latched;
   } rsp_type;

endpackage

@@ hw/rtl/apc_div.sv @@
module apc_div #(
   parameter int DEND_W = 28,
   parameter int DSOR_W = 12
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DEND_W-1:0] dividend,
   input  logic [DSOR_W-1:0] divisor,
   output logic              done,
   output logic [DEND_W-1:0] quotient
);
   localparam int CntW = $clog2(DEND_W + 1);

   logic [DEND_W-1:0] dq_ff, dq_in;
   logic [DSOR_W-1:0] rem_ff, rem_in;
   logic [DSOR_W-1:0] dsor_ff, dsor_in;
   logic [CntW-1:0]   cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DSOR_W:0]   trial;
   logic              fits;

   // restoring divide, one quotient bit per cycle; dividend shifts out as quotient shifts in
   assign trial = {rem_ff, dq_ff[DEND_W-1]};
   assign fits  = trial >= {1'b0, dsor_ff};

   always_comb begin
      dq_in   = dq_ff;
      rem_in  = rem_ff;
      dsor_in = dsor_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         dq_in   = dividend;
         rem_in  = '0;
         dsor_in = divisor;
         cnt_in  = CntW'(DEND_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? DSOR_W'(trial - {1'b0, dsor_ff}) : trial[DSOR_W-1:0];
         dq_in  = {dq_ff[DEND_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dq_ff   <= dq_in;
      rem_ff  <= rem_in;
      dsor_ff <= dsor_in;
   end

   assign done     = done_ff;
   assign quotient = dq_ff;
endmodule

@@ hw/rtl/apc_lane.sv @@
module apc_lane (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [apc_pkg::AdcW-1:0]  raw,
   input  logic [apc_pkg::AdcW-1:0]  lo,
   input  logic [apc_pkg::AdcW-1:0]  hi,
   output logic                      done,
   output logic [apc_pkg::FracW-1:0] frac
);
   import apc_pkg::*;

   localparam int DendW = AdcW + 16;

   logic            empty_ff, empty_in;
   logic            empty;
   logic [AdcW-1:0] clamped;
   logic [AdcW-1:0] span;
   logic [DendW-1:0] quot;

   // clamp to min..max, fraction = (v-min)<<16 / (max-min), zero when max <= min
   assign empty   = hi <= lo;
   assign clamped = (raw < lo) ? lo : ((raw > hi) ? hi : raw);
   assign span    = hi - lo;
   assign empty_in = start ? empty : empty_ff;

   apc_div #(.DEND_W(DendW), .DSOR_W(AdcW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .dividend ({AdcW'(clamped - lo), 16'b0}),
      .divisor  (span),
      .done     (done),
      .quotient (quot)
   );

   always_ff @(posedge clock) begin
      empty_ff <= empty_in;
   end

   assign frac = empty_ff ? '0 : quot[FracW-1:0];
endmodule

@@ hw/rtl/accelerator_pedal_conditioning.sv @@
// Words are taken one at a time: req_ready is high only in ST_IDLE and returns as the result
// is registered, and a stalled rsp_ready holds the next word off only while in ST_FIN.
// Time is set by the 28-step lane divides followed by the 33-step dead-zone divide.
// Reset (synchronous, active high) restores the calibration defaults and clears
// the smoothed level, the implausibility timer and the latched fault.
`include "assert_macros.svh"
module accelerator_pedal_conditioning #(
   parameter int TIME_BITS = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  apc_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output apc_pkg::rsp_type              rsp_data,
   input  logic                          csr_we,
   input  logic [apc_pkg::CsrIdxW-1:0]   csr_index,
   input  logic [apc_pkg::CsrW-1:0]      csr_wdata
);
   import apc_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE    = 7'b0000001,
      ST_FRAC    = 7'b0000010,
      ST_EMA_LD  = 7'b0000100,
      ST_EMA_DIV = 7'b0001000,
      ST_DZ_LD   = 7'b0010000,
      ST_DZ_DIV  = 7'b0100000,
      ST_FIN     = 7'b1000000
   } state_type;

   // ---------------- configuration registers ----------------
   logic [AdcW-1:0] s1_min_ff, s1_max_ff, s2_min_ff, s2_max_ff, offset_ff;
   logic [6:0]      tol_ff, dz_ff;
   logic [15:0]     fault_t_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_min_ff  <= S1MinRst;
         s1_max_ff  <= S1MaxRst;
         s2_min_ff  <= S2MinRst;
         s2_max_ff  <= S2MaxRst;
         offset_ff  <= OffRst;
         tol_ff     <= TolRst;
         dz_ff      <= DzRst;
         fault_t_ff <= FaultTRst;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_S1_MIN:  s1_min_ff  <= csr_wdata[AdcW-1:0];
            CSR_S1_MAX:  s1_max_ff  <= csr_wdata[AdcW-1:0];
            CSR_S2_MIN:  s2_min_ff  <= csr_wdata[AdcW-1:0];
            CSR_S2_MAX:  s2_max_ff  <= csr_wdata[AdcW-1:0];
            CSR_OFFSET:  offset_ff  <= csr_wdata[AdcW-1:0];
            CSR_TOL_PCT: tol_ff     <= csr_wdata[6:0];
            CSR_DZ_PCT:  dz_ff      <= csr_wdata[6:0];
            CSR_FAULT_T: fault_t_ff <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // ---------------- sequencer state ----------------
   state_type         state_ff, state_in;
   req_type           in_ff, in_in;
   logic [1:0]        lane_done_ff, lane_done_in;
   logic [TolProdW-1:0] tol_prod_ff, tol_prod_in;
   logic [ThrW-1:0]   thr_ff, thr_in;
   logic [EmaW-1:0]   ema_num_ff, ema_num_in;
   logic [LevelW-1:0] level_ff, level_in;
   logic              dz_zero_ff, dz_zero_in;
   logic [FracW-1:0]  throttle_ff, throttle_in;
   logic [TIME_BITS-1:0] since_ff, since_in;
   logic              run_ff, run_in;
   logic              fault_ff, fault_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic accept;
   logic fin_load;

   assign req_ready = state_ff == ST_IDLE;
   assign accept    = req_valid && req_ready;

   // ---------------- parallel sensor lanes ----------------
   logic [1:0]       lane_done;
   logic [FracW-1:0] frac1, frac2;

   apc_lane u_lane1 (
      .clock (clock), .reset (reset), .start (accept),
      .raw   (req_data.sensor1_raw), .lo (s1_min_ff), .hi (s1_max_ff),
      .done  (lane_done[0]), .frac (frac1)
   );

   apc_lane u_lane2 (
      .clock (clock), .reset (reset), .start (accept),
      .raw   (req_data.sensor2_raw), .lo (s2_min_ff), .hi (s2_max_ff),
      .done  (lane_done[1]), .frac (frac2)
   );

   // ---------------- tolerance window ----------------
   // thr = offset*pct/100 by reciprocal, two register stages; settles after a CSR write
   // long before any word reaches ST_FIN
   logic [2*TolProdW-1:0] thr_prod;

   assign tol_prod_in = TolProdW'(offset_ff) * TolProdW'(tol_ff);
   assign thr_prod    = (2*TolProdW)'(tol_prod_ff) * (2*TolProdW)'(Recip100);
   assign thr_in      = thr_prod[Recip100Sh +: ThrW];

   // ---------------- merge stage ----------------
   // EMA: level' = (level*49 + avg<<8)/50, numerator registered, then one reciprocal multiply
   // dead zone: throttle = (level*100 - dz<<24)/((100-dz)<<8) on the serial divider, clamped to 0..FracOne
   logic                  mdiv_start;
   logic [MergeDendW-1:0] mdiv_dend;
   logic [MergeDsorW-1:0] mdiv_dsor;
   logic                  mdiv_done;
   logic [MergeDendW-1:0] mdiv_q;

   apc_div #(.DEND_W(MergeDendW), .DSOR_W(MergeDsorW)) u_mdiv (
      .clock    (clock),
      .reset    (reset),
      .start    (mdiv_start),
      .dividend (mdiv_dend),
      .divisor  (mdiv_dsor),
      .done     (mdiv_done),
      .quotient (mdiv_q)
   );

   logic [FracW:0]        frac_sum;
   logic [FracW-1:0]      avg;
   logic [EmaW-1:0]       ema_num;
   logic [EmaW+30:0]      ema_prod;
   logic [6:0]            dz_sat;
   logic [6:0]            dz_span;
   logic [MergeDendW-1:0] dz_pos, dz_neg;
   logic                  frac_all;

   assign frac_sum = {1'b0, frac1} + {1'b0, frac2};
   assign avg      = frac_sum[FracW:1];
   assign ema_num  = EmaW'(level_ff) * EmaW'(SmoothN - 1) + (EmaW'(avg) << 8);
   assign ema_prod = (EmaW+31)'(ema_num_ff) * (EmaW+31)'(Recip50);
   assign dz_sat   = (dz_ff > DzMax) ? DzMax : dz_ff;
   assign dz_span  = 7'd100 - dz_sat;
   assign dz_pos   = MergeDendW'(level_ff) * MergeDendW'(100);
   assign dz_neg   = MergeDendW'(dz_sat) << 24;
   assign frac_all = (lane_done_ff[0] | lane_done[0]) & (lane_done_ff[1] | lane_done[1]);

   assign mdiv_start = state_ff == ST_DZ_LD;
   assign mdiv_dend  = dz_pos - dz_neg;
   assign mdiv_dsor  = {1'b0, dz_span, 8'b0};

   // ---------------- plausibility and fault timer ----------------
   logic [AdcW-1:0]      diff;
   logic                 range_ok, ok;
   logic [AdcW+1:0]      win_hi, diff_plus;
   logic [TIME_BITS-1:0] now_t, since_eff;
   logic                 expired;

   assign range_ok  = in_ff.sensor1_raw >= RawLow && in_ff.sensor2_raw >= RawLow
                   && in_ff.sensor1_raw <= RawHigh && in_ff.sensor2_raw <= RawHigh;
   assign diff      = (in_ff.sensor1_raw > in_ff.sensor2_raw)
                    ? in_ff.sensor1_raw - in_ff.sensor2_raw
                    : in_ff.sensor2_raw - in_ff.sensor1_raw;
   assign win_hi    = (AdcW+2)'(offset_ff) + (AdcW+2)'(thr_ff);
   assign diff_plus = (AdcW+2)'(diff) + (AdcW+2)'(thr_ff);
   // lower bound checked as diff + thr >= offset, no sign needed
   assign ok        = range_ok && ((AdcW+2)'(diff) <= win_hi)
                   && (diff_plus >= (AdcW+2)'(offset_ff));
   assign now_t     = in_ff.now_ms[TIME_BITS-1:0];
   assign since_eff = run_ff ? since_ff : now_t;
   assign expired   = TIME_BITS'(now_t - since_eff) > TIME_BITS'(fault_t_ff);
   assign fin_load  = (state_ff == ST_FIN) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in     = state_ff;
      in_in        = in_ff;
      lane_done_in = lane_done_ff | lane_done;
      ema_num_in   = ema_num_ff;
      level_in     = level_ff;
      dz_zero_in   = dz_zero_ff;
      throttle_in  = throttle_ff;
      since_in     = since_ff;
      run_in       = run_ff;
      fault_in     = fault_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               in_in        = req_data;
               lane_done_in = '0;
               state_in     = ST_FRAC;
            end
         end
         ST_FRAC: begin
            if (frac_all) begin
               state_in = ST_EMA_LD;
            end
         end
         ST_EMA_LD: begin
            ema_num_in = ema_num;
            state_in   = ST_EMA_DIV;
         end
         ST_EMA_DIV: begin
            level_in = ema_prod[Recip50Sh +: LevelW];
            state_in = ST_DZ_LD;
         end
         ST_DZ_LD: begin
            dz_zero_in = dz_pos <= dz_neg;
            state_in   = ST_DZ_DIV;
         end
         ST_DZ_DIV: begin
            if (mdiv_done) begin
               priority if (dz_zero_ff) begin
                  throttle_in = '0;
               end else if (mdiv_q > MergeDendW'(FracOne)) begin
                  throttle_in = FracOne;
               end else begin
                  throttle_in = mdiv_q[FracW-1:0];
               end
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (fin_load) begin
               fault_in = fault_ff && !in_ff.clear_fault;
               if (ok) begin
                  run_in   = 1'b0;
                  since_in = '0;
               end else begin
                  run_in   = 1'b1;
                  since_in = since_eff;
                  if (expired) begin
                     fault_in = 1'b1;
                  end
               end
               rsp_in.throttle      = throttle_ff;
               rsp_in.plausible_now = ok;
               rsp_in.fault_latched = ok ? fault_ff && !in_ff.clear_fault
                                         : (fault_ff && !in_ff.clear_fault) || expired;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         lane_done_ff <= '0;
         level_ff     <= '0;
         since_ff     <= '0;
         run_ff       <= 1'b0;
         fault_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lane_done_ff <= lane_done_in;
         level_ff     <= level_in;
         since_ff     <= since_in;
         run_ff       <= run_in;
         fault_ff     <= fault_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      in_ff       <= in_in;
      tol_prod_ff <= tol_prod_in;
      thr_ff      <= thr_in;
      ema_num_ff  <= ema_num_in;
      dz_zero_ff  <= dz_zero_in;
      throttle_ff <= throttle_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // ---------------- checks ----------------
   `APC_ASSERT(a_one_in_flight, clock, reset, accept |=> !req_ready)
   `APC_ASSERT(a_rsp_from_fin, clock, reset, (!rsp_valid_ff ##1 rsp_valid_ff) |-> $past(state_ff == ST_FIN))
   `APC_ASSERT(a_throttle_cap, clock, reset, rsp_valid_ff |-> (rsp_ff.throttle <= FracOne))
   `APC_ASSERT(a_fault_flag_out, clock, reset, $rose(rsp_valid_ff) |-> (rsp_ff.fault_latched == fault_ff))
endmodule

@@ tb/sv/tb.sv @@
module tb;
   import apc_pkg::*;

   // Pedal conditioning bench: valid/ready on both sides, CSR writes only
   // while the block is idle, scoreboard predicts each response word.

   localparam int WatchdogLimit = 20000;
   localparam int DrainCycles   = 200;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   req_type           req_data;
   logic              rsp_valid;
   logic              rsp_ready;
   rsp_type           rsp_data;
   logic              csr_we;
   logic [CsrIdxW-1:0] csr_index;
   logic [CsrW-1:0]   csr_wdata;

   accelerator_pedal_conditioning dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // Pedal predictor plus queue of expected response words.
   class pedal_scoreboard;
      logic [11:0] s1_min, s1_max, s2_min, s2_max, offset;
      logic [6:0]  tol_pct, dz_pct;
      logic [15:0] fault_t;
      logic [24:0] level;
      logic [31:0] since;
      bit          timing, fault;
      rsp_type     pending[$];
      int          errors;

      function void restore();
         s1_min = S1MinRst; s1_max = S1MaxRst; s2_min = S2MinRst; s2_max = S2MaxRst;
         offset = OffRst; tol_pct = TolRst; dz_pct = DzRst; fault_t = FaultTRst;
         level = '0; since = '0; timing = 0; fault = 0;
      endfunction

      function void set_reg(logic [CsrIdxW-1:0] idx, logic [CsrW-1:0] v);
         case (idx)
            CSR_S1_MIN:  s1_min = v[11:0];
            CSR_S1_MAX:  s1_max = v[11:0];
            CSR_S2_MIN:  s2_min = v[11:0];
            CSR_S2_MAX:  s2_max = v[11:0];
            CSR_OFFSET:  offset = v[11:0];
            CSR_TOL_PCT: tol_pct = v[6:0];
            CSR_DZ_PCT:  dz_pct = v[6:0];
            CSR_FAULT_T: fault_t = v;
            default: ;
         endcase
      endfunction

      function logic [16:0] scale(logic [11:0] v, logic [11:0] lo, logic [11:0] hi);
         logic [11:0] c;
         logic [63:0] n;
         if (hi <= lo) return '0;
         c = v < lo ? lo : (v > hi ? hi : v);
         n = 64'(c - lo) << 16;
         return 17'(n / 64'(hi - lo));
      endfunction

      function logic [63:0] tol_dz(logic [6:0] d);
         return d > DzMax ? 64'(DzMax) : 64'(d);
      endfunction

      function void note_request(req_type r);
         logic [17:0] avg;
         logic [63:0] nl, pos, neg, q, dz;
         longint      thr, diff;
         bit          ok;
         rsp_type     e;
         if (r.clear_fault) fault = 0;
         avg = (18'(scale(r.sensor1_raw, s1_min, s1_max)) +
                18'(scale(r.sensor2_raw, s2_min, s2_max))) >> 1;
         nl = (64'(level) * 49 + (64'(avg) << 8)) / 50;
         level = nl[24:0];
         dz = tol_dz(dz_pct);
         pos = 64'(level) * 100;
         neg = dz << 24;
         if (pos <= neg) q = 0;
         else q = (pos - neg) / ((100 - dz) << 8);
         e.throttle = q > 65536 ? FracOne : 17'(q);
         ok = 1;
         if (r.sensor1_raw < RawLow || r.sensor2_raw < RawLow) ok = 0;
         if (r.sensor1_raw > RawHigh || r.sensor2_raw > RawHigh) ok = 0;
         thr = (longint'(offset) * longint'(tol_pct)) / 100;
         diff = r.sensor1_raw > r.sensor2_raw ? longint'(r.sensor1_raw - r.sensor2_raw)
                                              : longint'(r.sensor2_raw - r.sensor1_raw);
         if (diff > longint'(offset) + thr || diff < longint'(offset) - thr) ok = 0;
         if (ok) begin
            timing = 0; since = '0;
         end else begin
            if (!timing) begin
               timing = 1; since = r.now_ms;
            end
            if (32'(r.now_ms - since) > 32'(fault_t)) fault = 1;
         end
         e.plausible_now = ok;
         e.fault_latched = fault;
         pending.push_back(e);
      endfunction

      function void check_response(rsp_type a);
         rsp_type e;
         if (pending.size() == 0) begin
            $display("%0t unexpected response word: exp none act %h", $time, a);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (a.throttle !== e.throttle) begin
            $display("%0t throttle: exp %0d act %0d", $time, e.throttle, a.throttle);
            errors++;
         end
         if (a.plausible_now !== e.plausible_now) begin
            $display("%0t plausible_now: exp %0d act %0d", $time, e.plausible_now,
                     a.plausible_now);
            errors++;
         end
         if (a.fault_latched !== e.fault_latched) begin
            $display("%0t fault_latched: exp %0d act %0d", $time, e.fault_latched,
                     a.fault_latched);
            errors++;
         end
      endfunction
   endclass

   pedal_scoreboard sb;
   int   idle_cycles;
   bit   calm;          // no idling in the final stretch
   bit   timed_out;
   logic [31:0] clock_ms;

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   // Response side: random stall bursts, checks on every accepted word.
   int rsp_hold;
   initial begin
      rsp_ready <= 0;
      rsp_hold = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) sb.check_response(rsp_data);
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_ready <= 0;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            rsp_hold = $urandom_range(1, 13) - 1;
            rsp_ready <= 0;
         end else rsp_ready <= 1;
      end
   end

   // Watchdog: cycles without any accepted word.
   initial begin
      idle_cycles = 0;
      timed_out = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WatchdogLimit) begin
            $display("[accelerator_pedal_conditioning] ERROR");
            $finish;
         end
      end
   end

   // valid stays up between words sent back to back; it drops for a gap or a drain
   task automatic send_word(req_type w);
      int gap;
      if (!calm && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 13);
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_data  <= w;
      do @(posedge clock); while (!req_ready);
      sb.note_request(w);
   endtask

   task automatic write_reg(logic [CsrIdxW-1:0] idx, logic [CsrW-1:0] v);
      csr_we    <= 1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      sb.set_reg(idx, v);
      csr_we    <= 0;
   endtask

   task automatic wait_drained();
      req_valid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   function automatic req_type make_word(logic [11:0] a, logic [11:0] b, bit clr);
      req_type w;
      w.sensor1_raw = a;
      w.sensor2_raw = b;
      w.now_ms      = clock_ms;
      w.clear_fault = clr;
      return w;
   endfunction

   // Mostly realistic pedal travel with the configured offset, some noise.
   task automatic random_phase(int n);
      logic [11:0] a, b;
      int          k;
      for (k = 0; k < n; k++) begin
         clock_ms += $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 40);
         a = 12'($urandom_range(0, 4095));
         if ($urandom_range(0, 3) != 0) b = 12'(a - sb.offset + $urandom_range(0, 60) - 30);
         else b = 12'($urandom_range(0, 4095));
         send_word(make_word(a, b, $urandom_range(0, 7) == 0));
      end
   endtask

   initial begin
      int k;
      sb = new();
      sb.restore();
      sb.errors = 0;
      calm = 0;
      clock_ms = 32'hFFFF_FF00;   // forces a timestamp wrap early
      reset <= 1;
      req_valid <= 0;
      req_data <= '0;
      csr_we <= 0;
      csr_index <= '0;
      csr_wdata <= '0;
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: field extremes, plausibility edges, fault timing, clear.
      send_word(make_word(12'd0, 12'd0, 0));
      send_word(make_word(12'hFFF, 12'hFFF, 1));
      send_word(make_word(12'd3600, 12'd2320, 0));
      send_word(make_word(12'd1800, 12'd520, 0));
      send_word(make_word(12'd99, 12'd1379, 0));
      send_word(make_word(12'd4051, 12'd2771, 0));
      send_word(make_word(12'd2800, 12'd1648, 0));   // diff at lower bound
      send_word(make_word(12'd2800, 12'd1647, 0));
      send_word(make_word(12'd2800, 12'd1392, 0));   // diff at upper bound
      clock_ms += 100;
      send_word(make_word(12'd2800, 12'd1391, 0));
      clock_ms += 101;
      send_word(make_word(12'd2800, 12'd1391, 0));   // fault latches here
      send_word(make_word(12'd2800, 12'd1520, 0));
      send_word(make_word(12'd2800, 12'd1520, 1));
      clock_ms = 32'hFFFF_FFFF;
      send_word(make_word(12'd0, 12'd1520, 0));
      clock_ms = 32'd200;
      send_word(make_word(12'd0, 12'd1520, 0));      // timer across wrap
      for (k = 0; k < 6; k++) send_word(make_word(12'hFFF, 12'hFFF, 0));
      wait_drained();

      // Empty sensor 1 span, tolerance above offset, dead zone beyond 99, zero fault time.
      write_reg(CSR_S1_MIN, 16'd4095);
      write_reg(CSR_S1_MAX, 16'd0);
      write_reg(CSR_S2_MIN, 16'd0);
      write_reg(CSR_S2_MAX, 16'd4095);
      write_reg(CSR_OFFSET, 16'd10);
      write_reg(CSR_TOL_PCT, 16'd127);
      write_reg(CSR_DZ_PCT, 16'd127);
      write_reg(CSR_FAULT_T, 16'd0);
      send_word(make_word(12'd500, 12'd500, 0));
      send_word(make_word(12'd500, 12'd4095, 0));
      random_phase(200);
      wait_drained();

      write_reg(CSR_S1_MIN, 16'd0);
      write_reg(CSR_S1_MAX, 16'd4095);
      write_reg(CSR_OFFSET, 16'd0);
      write_reg(CSR_TOL_PCT, 16'd0);
      write_reg(CSR_DZ_PCT, 16'd0);
      write_reg(CSR_FAULT_T, 16'hFFFF);
      random_phase(200);
      wait_drained();

      write_reg(CSR_S2_MIN, 16'd1000);
      write_reg(CSR_S2_MAX, 16'd1001);
      write_reg(CSR_OFFSET, 16'd4095);
      write_reg(CSR_TOL_PCT, 16'd100);
      write_reg(CSR_DZ_PCT, 16'd99);
      write_reg(CSR_FAULT_T, 16'd30);
      random_phase(200);
      wait_drained();

      // Back to calibration defaults; last stretch runs without idling.
      write_reg(CSR_S1_MIN, CsrW'(S1MinRst));
      write_reg(CSR_S1_MAX, CsrW'(S1MaxRst));
      write_reg(CSR_S2_MIN, CsrW'(S2MinRst));
      write_reg(CSR_S2_MAX, CsrW'(S2MaxRst));
      write_reg(CSR_OFFSET, CsrW'(OffRst));
      write_reg(CSR_TOL_PCT, CsrW'(TolRst));
      write_reg(CSR_DZ_PCT, CsrW'(DzRst));
      write_reg(CSR_FAULT_T, 16'd100);
      random_phase(250);
      calm = 1;
      random_phase(150);
      wait_drained();

      if (sb.errors == 0) $display("[accelerator_pedal_conditioning] OK");
      else $display("[accelerator_pedal_conditioning] ERROR");
      $finish;
   end
endmodule
